// ===== rtl/dprq_pkg.sv =====
`default_nettype none
package dprq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_UNREL = 2'd0;
  localparam logic [1:0] KIND_ORD   = 2'd1;
  localparam logic [1:0] KIND_REL   = 2'd2;

  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  // one queued packet
  typedef struct packed {
    logic [31:0] rel_time;
    logic [31:0] seq;
    logic [31:0] tag;
    logic [1:0]  kind;
  } entry_t;

  // per-cycle commands shared by all cells
  typedef struct packed {
    logic drop;  // shift whole row toward the head
    logic take;  // shift from the selected packet on
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dprq_cell.sv =====
`default_nettype none
module dprq_cell
  import dprq_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctl_t  ctl_i,
  input  wire        load_i,
  input  entry_t     push_i,
  input  entry_t     next_i,
  input  wire        valid_i,
  input  wire [31:0] now_i,
  input  wire [31:0] rel_next_i,
  input  wire        hit_i,
  input  entry_t     acc_i,
  output entry_t     entry_o,
  output logic       hit_o,
  output entry_t     acc_o
);

  entry_t entry_q;
  logic   own_hit;

  // due and, for reliable packets, next in line
  always_comb begin
    own_hit = valid_i && (entry_q.rel_time <= now_i) &&
              ((entry_q.kind != KIND_REL) || (entry_q.seq == rel_next_i)) && !hit_i;
    hit_o   = hit_i | own_hit;
    acc_o   = own_hit ? entry_q : acc_i;
  end

  // shift from neighbor or load at tail
  always_ff @(posedge clk_i) begin
    if (ctl_i.drop || (ctl_i.take && hit_o)) begin
      entry_q <= next_i;
    end else if (load_i) begin
      entry_q <= push_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== rtl/delayed_packet_release_queue_core.sv =====
// delayed packet release queue
// input words on s_axis: tuser selects push (0) or take (1); a push stores a
// packet with its release tick, a take drops stale ordered packets at the head
// and then releases the first due packet in queue order, reliable ones only in sequence.
// every input word yields exactly one output word on m_axis: tuser carries the
// status, tdata the delivered packet, its sequence and the stale drop count.
// the queue is a row of cells that shift toward the head; each cell compares
// its own packet against the current tick in parallel.
// a push result is registered into the output state the cycle after the word is
// accepted; a take first passes through the take state, where it stays while
// stale packets are dropped one at a time, and then enters the output state.
// a new word is accepted only once the previous result has been taken.
// when m_axis_tready is low the result holds and s_axis_tready stays low.
// reset empties the queue, sets both sequence counters to one and clears the
// last handled sequence numbers.
`default_nettype none
module delayed_packet_release_queue_core
  import dprq_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] delivery_kind, [33:2] packet_tag, [65:34] release_time, [97:66] now_time
  input  wire  [103:0] s_axis_tdata,
  // [0] mode
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [31:0] out_tag, [33:32] out_kind, [65:34] out_sequence, [70:66] stale_dropped
  output logic [71:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TAKE = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      next_ord_q, next_ord_d, next_rel_q, next_rel_d;
  logic [31:0]      last_ord_q, last_ord_d, last_rel_q, last_rel_d;
  logic [31:0]      now_q, now_d;
  logic [4:0]       drop_q, drop_d;
  logic [1:0]       status_q, status_d;
  entry_t           res_q, res_d;

  cell_ctl_t        ctl;
  logic             load_en;
  entry_t           push_ent;
  entry_t           ent   [QUEUE_DEPTH];
  entry_t           acc   [QUEUE_DEPTH+1];
  logic             hit   [QUEUE_DEPTH+1];
  logic             stale;
  logic             in_fire;
  logic [1:0]       in_kind;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_kind = s_axis_tdata[1:0];

  // stale ordered packet at the head
  assign stale = (fill_q != '0) && (ent[0].kind == KIND_ORD) && (ent[0].seq <= last_ord_q);

  // row of cells
  assign hit[0] = 1'b0;
  assign acc[0] = '0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nxt;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = ent[i];
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    dprq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .load_i     (load_en && (fill_q == CNT_W'(i))),
      .push_i     (push_ent),
      .next_i     (nxt),
      .valid_i    (CNT_W'(i) < fill_q),
      .now_i      (now_q),
      .rel_next_i (last_rel_q + 32'd1),
      .hit_i      (hit[i]),
      .acc_i      (acc[i]),
      .entry_o    (ent[i]),
      .hit_o      (hit[i+1]),
      .acc_o      (acc[i+1])
    );
  end

  // control
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    next_ord_d = next_ord_q;
    next_rel_d = next_rel_q;
    last_ord_d = last_ord_q;
    last_rel_d = last_rel_q;
    now_d      = now_q;
    drop_d     = drop_q;
    status_d   = status_q;
    res_d      = res_q;
    ctl        = '0;
    load_en    = 1'b0;
    push_ent.rel_time = s_axis_tdata[65:34];
    push_ent.tag      = s_axis_tdata[33:2];
    push_ent.kind     = KIND_UNREL;
    push_ent.seq      = '0;
    if (in_kind == KIND_ORD) begin
      push_ent.kind = KIND_ORD;
      push_ent.seq  = next_ord_q;
    end else if (in_kind == KIND_REL) begin
      push_ent.kind = KIND_REL;
      push_ent.seq  = next_rel_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          drop_d = '0;
          res_d  = '0;
          if (s_axis_tuser) begin
            now_d   = s_axis_tdata[97:66];
            state_d = S_TAKE;
          end else begin
            state_d = S_OUT;
            if (fill_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              status_d  = ST_PUSHED;
              load_en   = 1'b1;
              fill_d    = fill_q + 1'b1;
              res_d.seq = push_ent.seq;
              if (push_ent.kind == KIND_ORD) next_ord_d = next_ord_q + 32'd1;
              if (push_ent.kind == KIND_REL) next_rel_d = next_rel_q + 32'd1;
            end
          end
        end
      end
      S_TAKE: begin
        if (stale) begin
          ctl.drop = 1'b1;
          fill_d   = fill_q - 1'b1;
          if (drop_q != 5'd31) drop_d = drop_q + 5'd1;
        end else begin
          state_d = S_OUT;
          if (hit[QUEUE_DEPTH]) begin
            ctl.take = 1'b1;
            fill_d   = fill_q - 1'b1;
            status_d = ST_DELIVERED;
            res_d    = acc[QUEUE_DEPTH];
            if (acc[QUEUE_DEPTH].kind == KIND_ORD) last_ord_d = acc[QUEUE_DEPTH].seq;
            if (acc[QUEUE_DEPTH].kind == KIND_REL) last_rel_d = acc[QUEUE_DEPTH].seq;
          end else begin
            status_d = ST_NONE;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      next_ord_q <= 32'd1;
      next_rel_q <= 32'd1;
      last_ord_q <= '0;
      last_rel_q <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      next_ord_q <= next_ord_d;
      next_rel_q <= next_rel_d;
      last_ord_q <= last_ord_d;
      last_rel_q <= last_rel_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    drop_q   <= drop_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  // output word
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {1'b0, drop_q, res_q.seq, res_q.kind, res_q.tag};

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// scoreboard: packet queue predictor plus the store of expected result words
class release_scoreboard;
  dprq_pkg::entry_t slots[$];
  logic [31:0] next_ord_num, next_rel_num, last_ord_done, last_rel_done;
  logic [73:0] expected_words[$];  // {status, tdata}
  int mismatch_count;

  function new();
    next_ord_num = 32'd1;
    next_rel_num = 32'd1;
    last_ord_done = '0;
    last_rel_done = '0;
    mismatch_count = 0;
  endfunction

  // predict the result of one accepted input word
  function void note_input(logic mode, logic [1:0] kind, logic [31:0] tag,
                           logic [31:0] rel, logic [31:0] now);
    dprq_pkg::entry_t e;
    logic [1:0] st;
    logic [31:0] otag, oseq;
    logic [1:0] okind;
    logic [4:0] dropped;
    logic found;
    st = dprq_pkg::ST_NONE;
    otag = '0;
    oseq = '0;
    okind = '0;
    dropped = '0;
    found = 1'b0;
    if (mode == 1'b0) begin
      if (slots.size() >= dprq_pkg::QUEUE_DEPTH) begin
        st = dprq_pkg::ST_FULL;
      end else begin
        e.seq = '0;
        if (kind == dprq_pkg::KIND_ORD) begin
          e.seq = next_ord_num;
          next_ord_num++;
        end else if (kind == dprq_pkg::KIND_REL) begin
          e.seq = next_rel_num;
          next_rel_num++;
        end else begin
          kind = dprq_pkg::KIND_UNREL;
        end
        e.kind = kind;
        e.tag = tag;
        e.rel_time = rel;
        slots.insert(slots.size(), e);
        st = dprq_pkg::ST_PUSHED;
        oseq = e.seq;
      end
    end else begin
      // stale ordered packets at the head
      while (slots.size() > 0 && slots[0].kind == dprq_pkg::KIND_ORD &&
             slots[0].seq <= last_ord_done) begin
        void'(slots.pop_front());
        if (dropped < 5'd31) dropped++;
      end
      // first due packet in queue order
      for (int i = 0; i < slots.size() && !found; i++) begin
        if (slots[i].rel_time <= now) begin
          if (slots[i].kind == dprq_pkg::KIND_ORD) begin
            last_ord_done = slots[i].seq;
            found = 1'b1;
          end else if (slots[i].kind == dprq_pkg::KIND_REL) begin
            if (slots[i].seq == last_rel_done + 32'd1) begin
              last_rel_done = slots[i].seq;
              found = 1'b1;
            end
          end else begin
            found = 1'b1;
          end
          if (found) begin
            otag = slots[i].tag;
            okind = slots[i].kind;
            oseq = slots[i].seq;
            slots.delete(i);
          end
        end
      end
      st = found ? dprq_pkg::ST_DELIVERED : dprq_pkg::ST_NONE;
    end
    expected_words.insert(expected_words.size(), {st, 1'b0, dropped, oseq, okind, otag});
  endfunction

  // compare one result word with the oldest expectation
  function void check_result(logic [1:0] st, logic [71:0] data);
    logic [73:0] exp_w;
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result st=%0d data=%h", st, data);
      return;
    end
    exp_w = expected_words.pop_front();
    if (exp_w[73:72] !== st || exp_w[31:0] !== data[31:0] ||
        exp_w[33:32] !== data[33:32] || exp_w[65:34] !== data[65:34] ||
        exp_w[70:66] !== data[70:66]) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"mismatch: expected st=%0d tag=%h kind=%0d seq=%h drop=%0d, ",
                  "got st=%0d tag=%h kind=%0d seq=%h drop=%0d"},
                 exp_w[73:72], exp_w[31:0], exp_w[33:32], exp_w[65:34], exp_w[70:66],
                 st, data[31:0], data[33:32], data[65:34], data[70:66]);
    end
  endfunction
endclass

module testbench;
  import dprq_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  release_scoreboard board = new();
  bit quiet_phase = 1'b0;
  logic [31:0] tick_base = '0;

  delayed_packet_release_queue_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stall bursts, check every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata);
  end

  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // send one word and wait for its handshake
  task automatic send_word(logic mode, logic [1:0] kind, logic [31:0] tag,
                           logic [31:0] rel, logic [31:0] now);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {6'd0, now, rel, tag, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_input(mode, kind, tag, rel, now);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_pkt(logic [1:0] kind, logic [31:0] tag, logic [31:0] rel);
    send_word(1'b0, kind, tag, rel, $urandom());
  endtask

  task automatic take_pkt(logic [31:0] now);
    send_word(1'b1, 2'($urandom_range(0, 3)), $urandom(), $urandom(), now);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all classes, class three, extremes, full queue, nothing due
    take_pkt(32'hFFFF_FFFF);
    push_pkt(KIND_UNREL, 32'hFFFF_FFFF, 32'h0);
    push_pkt(KIND_ORD, 32'h0, 32'hFFFF_FFFF);
    push_pkt(KIND_REL, 32'hA5A5_5A5A, 32'd10);
    push_pkt(2'd3, 32'h5A5A_A5A5, 32'd5);
    take_pkt(32'h0);
    take_pkt(32'd9);
    take_pkt(32'd10);
    for (int i = 0; i < 14; i++) push_pkt(2'(i % 3), 32'(i), 32'hFFFF_FFFF);
    push_pkt(KIND_ORD, 32'hDEAD_BEEF, 32'd1);
    take_pkt(32'hFFFF_FFFE);
    take_pkt(32'hFFFF_FFFF);
    wait_drained();
    for (int i = 0; i < 20; i++) take_pkt(32'hFFFF_FFFF);
    wait_drained();

    // random: pushes with near ticks, takes that advance the clock, rare random words
    for (int i = 0; i < 500; i++) begin
      if (i > 440) quiet_phase = 1'b1;
      if (i == 250) wait_drained();
      if ($urandom_range(0, 19) == 0) begin
        send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom(),
                  $urandom(), $urandom());
      end else if ($urandom_range(0, 1) == 0) begin
        push_pkt(2'($urandom_range(0, 3)), $urandom(), tick_base + $urandom_range(0, 40));
      end else begin
        tick_base = tick_base + $urandom_range(0, 10);
        take_pkt(tick_base + $urandom_range(0, 20));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
